// ===== rtl/dcc_pkg.sv =====
// Package for the Chio condensation determinant core.
// Holds sizing constants and the sequencer state type; no dependencies.
package dcc_pkg;
    localparam int unsigned MAX_N_DEF        = 5;
    localparam int unsigned ELEMENT_BITS_DEF = 12;
    localparam int unsigned DET_BITS         = 64;
    localparam int unsigned CFG_BITS         = 3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIVOT,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_WRITE,
        ST_OUT
    } t_state;
endpackage

// ===== rtl/determinant_chio_condensation_core.sv =====
// Determinant core by fraction-free Chio condensation.
// Top level; uses dcc_pkg and dcc_divider.
//
// - i_cfg_we/i_cfg_wdata set the matrix order n (clamped to 2..MAX_N); a write in
//   ST_LOAD restarts the load. Written only while no transaction is in flight.
// - n*n entries arrive row-major on i_element (i_valid/o_stall), one input
//   transaction per cycle, into a 25 x 64 synchronous RAM.
// - After the last entry each pass writes the condensed matrix one row and one
//   column further down the RAM, so the pass's top row and left column stay intact.
// - Each condensed entry takes three RAM reads, 32x32 partial products accumulated
//   at 128 bits, one divider start, a restoring division and one write, in that
//   order; each pass begins with a pivot check.
// - One result transaction (o_determinant, o_status) follows; status 1 means a
//   zero pivot was met and the determinant reads 0.
// - o_stall stays high from the last entry until the result is taken; the result
//   holds while i_stall is high.
// - Reset (synchronous, active low) sets n = 2, clears the load count and the
//   output valid. RAM contents are not cleared.
module determinant_chio_condensation_core #(
    parameter int unsigned MAX_N        = dcc_pkg::MAX_N_DEF,
    parameter int unsigned ELEMENT_BITS = dcc_pkg::ELEMENT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dcc_pkg::CFG_BITS-1:0]    i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [ELEMENT_BITS-1:0]  i_element,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [dcc_pkg::DET_BITS-1:0] o_determinant,
    output logic                            o_status
);
    import dcc_pkg::*;
    localparam int unsigned DEPTH = MAX_N*MAX_N;
    localparam int unsigned AB    = $clog2(DEPTH);
    localparam int unsigned NB    = $clog2(MAX_N+1);
    localparam int unsigned CNTB  = $clog2(DEPTH+1);
    localparam int unsigned WB    = 2*DET_BITS;

    // matrix RAM
    logic [DET_BITS-1:0] mem [DEPTH];
    logic [DET_BITS-1:0] r_rd;
    logic [AB-1:0]       w_raddr;
    logic                w_we;
    logic [AB-1:0]       w_waddr;
    logic [DET_BITS-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rd <= mem[w_raddr];
    end

    function automatic logic [AB-1:0] f_addr(input logic [NB-1:0] row,
                                             input logic [NB-1:0] col);
        return AB'(32'(row)*MAX_N + 32'(col));
    endfunction

    t_state r_state, n_state;
    logic [NB-1:0]   r_n;
    logic [NB-1:0]   r_row, r_col;
    logic [NB-1:0]   r_s;
    logic [NB-1:0]   r_base;
    logic [CNTB-1:0] r_cnt;
    logic [DET_BITS-1:0] r_pivot, r_first, r_prev, r_lr, r_top, r_left;
    logic [WB-1:0]   r_acc;
    logic [1:0]      r_mph;
    logic [1:0]      r_part;
    logic [DET_BITS-1:0] r_det;
    logic            r_bad;
    logic            w_div_start;
    logic            w_div_done;
    logic [DET_BITS-1:0] w_q;

    // config clamp
    logic [NB-1:0] w_cfg_n;
    always_comb begin
        if (i_cfg_wdata < CFG_BITS'(2)) w_cfg_n = NB'(2);
        else if (32'(i_cfg_wdata) > MAX_N) w_cfg_n = NB'(MAX_N);
        else w_cfg_n = NB'(i_cfg_wdata);
    end

    logic            w_in_acc, w_last, w_pass_end, w_row_end;
    logic [CNTB-1:0] w_nn_m1;
    assign o_stall    = (r_state != ST_LOAD);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_nn_m1    = CNTB'(32'(r_n)*32'(r_n) - 32'd1);
    assign w_last     = (r_cnt == w_nn_m1);
    assign w_row_end  = (r_col == r_s - NB'(2));
    assign w_pass_end = (r_row == r_s - NB'(2)) && w_row_end;

    // magnitudes for 32x32 partial products
    logic [DET_BITS-1:0] w_ma, w_mb;
    logic                w_sgn;
    logic [31:0]         w_pa, w_pb;
    logic [63:0]         w_pp;
    logic [WB-1:0]       w_term;
    always_comb begin
        logic [DET_BITS-1:0] a, b;
        if (r_mph == 2'd0) begin a = r_pivot; b = r_lr; end
        else begin a = r_top; b = r_left; end
        w_ma  = a[DET_BITS-1] ? (~a + 1'b1) : a;
        w_mb  = b[DET_BITS-1] ? (~b + 1'b1) : b;
        w_sgn = a[DET_BITS-1] ^ b[DET_BITS-1];
        w_pa  = r_part[1] ? w_ma[63:32] : w_ma[31:0];
        w_pb  = r_part[0] ? w_mb[63:32] : w_mb[31:0];
    end
    logic [63:0] r_pp;
    logic        r_pp_v;
    logic [6:0]  r_sh;
    logic        r_psgn;
    assign w_pp   = w_pa * w_pb;
    assign w_term = {64'd0, r_pp} << r_sh;

    dcc_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(r_acc),
        .i_divisor (r_prev),
        .o_done    (w_div_done),
        .o_quotient(w_q)
    );

    // addresses; a pass of order s reads the matrix at offset (base, base)
    logic [AB-1:0] w_ld_addr, w_lr_addr, w_top_addr, w_left_addr;
    assign w_ld_addr   = f_addr(r_row, r_col);
    assign w_lr_addr   = f_addr(r_base + r_row + NB'(1), r_base + r_col + NB'(1));
    assign w_top_addr  = f_addr(r_base, r_base + r_col + NB'(1));
    assign w_left_addr = f_addr(r_base + r_row + NB'(1), r_base);

    always_comb begin
        n_state     = r_state;
        w_raddr     = w_lr_addr;
        w_we        = 1'b0;
        w_waddr     = w_ld_addr;
        w_wdata     = DET_BITS'(i_element);
        w_div_start = 1'b0;
        case (r_state)
            ST_LOAD: begin
                w_we = w_in_acc;
                if (w_in_acc && !i_cfg_we && w_last) n_state = ST_PIVOT;
            end
            // pivot of the final 2x2 is no divisor and is not checked
            ST_PIVOT: begin
                if (r_s >= NB'(3) && r_pivot == '0) n_state = ST_OUT;
                else n_state = ST_RD_A;
            end
            ST_RD_A: begin
                w_raddr = w_lr_addr;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                w_raddr = w_top_addr;
                n_state = ST_RD_C;
            end
            ST_RD_C: begin
                w_raddr = w_left_addr;
                n_state = ST_MUL;
            end
            ST_MUL: if (r_mph == 2'd2 && !r_pp_v) n_state = ST_DIV_START;
            ST_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: if (w_div_done) n_state = ST_WRITE;
            ST_WRITE: begin
                // new entry lands on its own lower-right source
                w_we    = (r_s != NB'(2));
                w_waddr = w_lr_addr;
                w_wdata = w_q;
                if (r_s == NB'(2)) n_state = ST_OUT;
                else if (w_pass_end) n_state = ST_PIVOT;
                else n_state = ST_RD_A;
            end
            ST_OUT: if (!i_stall) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_n     <= NB'(2);
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_prev  <= DET_BITS'(1);
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    if (i_cfg_we) begin
                        r_n   <= w_cfg_n;
                        r_cnt <= '0;
                        r_row <= '0;
                        r_col <= '0;
                    end else if (w_in_acc) begin
                        if (r_cnt == '0) r_pivot <= DET_BITS'(i_element);
                        if (w_last) begin
                            r_cnt  <= '0;
                            r_row  <= '0;
                            r_col  <= '0;
                            r_s    <= r_n;
                            r_base <= '0;
                            r_prev <= DET_BITS'(1);
                            r_bad  <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                            if (r_col == r_n - NB'(1)) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else r_col <= r_col + 1'b1;
                        end
                    end
                end
                ST_PIVOT: begin
                    if (r_s >= NB'(3) && r_pivot == '0) begin
                        r_bad <= 1'b1;
                        r_det <= '0;
                    end
                end
                ST_RD_B: r_lr <= r_rd;
                ST_RD_C: begin
                    r_top  <= r_rd;
                    r_mph  <= 2'd0;
                    r_part <= '0;
                    r_acc  <= '0;
                    r_pp_v <= 1'b0;
                end
                ST_MUL: begin
                    // left-column read lands in the first multiply cycle
                    if (r_mph == 2'd0 && r_part == '0 && !r_pp_v) r_left <= r_rd;
                    if (r_pp_v) r_acc <= r_psgn ? r_acc - w_term : r_acc + w_term;
                    if (r_mph != 2'd2) begin
                        r_pp   <= w_pp;
                        r_pp_v <= 1'b1;
                        r_sh   <= 7'(32*(32'(r_part[1]) + 32'(r_part[0])));
                        r_psgn <= w_sgn ^ r_mph[0];
                        r_part <= r_part + 1'b1;
                        if (r_part == 2'd3) r_mph <= r_mph + 1'b1;
                    end else r_pp_v <= 1'b0;
                end
                ST_WRITE: begin
                    if (r_s == NB'(2)) begin
                        r_det <= w_q;
                    end else begin
                        // first entry of the pass is the next pivot
                        if (r_row == '0 && r_col == '0) r_first <= w_q;
                        if (w_pass_end) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_s     <= r_s - 1'b1;
                            r_base  <= r_base + 1'b1;
                            r_prev  <= r_pivot;
                            r_pivot <= r_first;
                        end else if (w_row_end) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else r_col <= r_col + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = (r_state == ST_OUT);
    assign o_status      = r_bad;
    assign o_determinant = r_det;
endmodule

// ===== rtl/dcc_divider.sv =====
// Restoring divider: signed 128-bit dividend by signed 64-bit divisor.
// One quotient bit per cycle, exact quotient truncated to 64 bits. Uses dcc_pkg.
module dcc_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [2*dcc_pkg::DET_BITS-1:0] i_dividend,
    input  logic [dcc_pkg::DET_BITS-1:0] i_divisor,
    output logic                         o_done,
    output logic [dcc_pkg::DET_BITS-1:0] o_quotient
);
    import dcc_pkg::*;
    localparam int unsigned WB = 2*DET_BITS;
    localparam int unsigned CB = $clog2(WB);

    logic [WB-1:0]       r_num;
    logic [DET_BITS-1:0] r_dm;
    logic [DET_BITS-1:0] r_rem;
    logic [DET_BITS-1:0] r_q;
    logic                r_neg;
    logic [CB-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DET_BITS:0]   w_trial;
    logic [DET_BITS:0]   w_diff;

    assign w_trial = {r_rem, r_num[WB-1]};
    assign w_diff  = w_trial - {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_num  <= i_dividend[WB-1] ? (~i_dividend + 1'b1) : i_dividend;
                r_dm   <= i_divisor[DET_BITS-1] ? (~i_divisor + 1'b1) : i_divisor;
                r_neg  <= i_dividend[WB-1] ^ i_divisor[DET_BITS-1];
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[WB-2:0], 1'b0};
                if (w_trial >= {1'b0, r_dm}) begin
                    r_rem <= w_diff[DET_BITS-1:0];
                    r_q   <= {r_q[DET_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[DET_BITS-1:0];
                    r_q   <= {r_q[DET_BITS-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_q + 1'b1) : r_q;
endmodule

// ===== dv/determinant_chio_condensation_core_tb.sv =====
// Testbench for determinant_chio_condensation_core: loads integer matrices of
// order 2..5 and checks each determinant/status against an exact predictor.
// Depends on dcc_pkg and the core RTL only.
module determinant_chio_condensation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcc_pkg::*;

    localparam int MAXN = MAX_N_DEF;
    localparam int EBITS = ELEMENT_BITS_DEF;

    typedef struct packed {
        logic signed [63:0] det;
        logic               status;
    } t_det_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_BITS-1:0]    i_cfg_wdata;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [EBITS-1:0] i_element;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [63:0]     o_determinant;
    logic                   o_status;

    determinant_chio_condensation_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_element     (i_element),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_determinant (o_determinant),
        .o_status      (o_status)
    );

    // Predictor state: mirror of the core's matrix, load count and order.
    logic signed [63:0] pred_mat [MAXN*MAXN];
    int                 pred_count;
    int                 pred_order;
    t_det_result        det_queue [$];

    int  mismatches;
    bit  idle_enable;   // random bubbles/back-pressure allowed
    bit  done_flag;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous limit: the items of every test plus random stalls fit easily.
    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    // Exact (a*b - c*d)/div at 128 bits; SV native signed division truncates,
    // and the quotient is exact, so this matches the fraction-free step.
    function automatic logic signed [63:0] cross_quot(
        logic signed [63:0] a, logic signed [63:0] b,
        logic signed [63:0] c, logic signed [63:0] d,
        logic signed [63:0] div);
        logic signed [127:0] t;
        logic signed [127:0] q;
        t = 128'(a) * 128'(b) - 128'(c) * 128'(d);
        q = t / 128'(div);
        return q[63:0];
    endfunction

    // Accept one entry into the predictor; push a result on the last one.
    task automatic predict_entry(logic signed [EBITS-1:0] e);
        logic signed [63:0] top [MAXN];
        logic signed [63:0] left [MAXN];
        logic signed [63:0] pivot, prev;
        t_det_result r;
        bit bad;
        int s, i, j;
        pred_mat[(pred_count / pred_order) * MAXN + (pred_count % pred_order)] = 64'(e);
        pred_count++;
        if (pred_count < pred_order * pred_order)
            return;
        bad = 1'b0;
        prev = 64'sd1;
        for (s = pred_order; s >= 3; s--) begin
            pivot = pred_mat[0];
            if (pivot == 0) begin
                bad = 1'b1;
                break;
            end
            for (i = 0; i < s; i++) begin
                top[i] = pred_mat[i];
                left[i] = pred_mat[i*MAXN];
            end
            for (i = 0; i + 1 < s; i++)
                for (j = 0; j + 1 < s; j++)
                    pred_mat[i*MAXN+j] = cross_quot(pivot, pred_mat[(i+1)*MAXN+j+1],
                                                    top[j+1], left[i+1], prev);
            prev = pivot;
        end
        r.status = bad;
        r.det = bad ? 64'sd0
                    : cross_quot(pred_mat[0], pred_mat[MAXN+1], pred_mat[1],
                                 pred_mat[MAXN], prev);
        det_queue.push_back(r);
        pred_count = 0;
    endtask

    // Send one entry; a random bubble may precede it while idling is enabled.
    // Valid stays high after acceptance; callers that pause drop it.
    task automatic send_entry(logic signed [EBITS-1:0] e);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_element <= e;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_entry(e);
    endtask

    task automatic send_matrix_random(int kind);
        int k;
        logic signed [EBITS-1:0] e;
        for (k = 0; k < pred_order * pred_order; k++) begin
            case (kind)
                0: e = EBITS'($urandom);
                1: e = EBITS'($signed($urandom_range(0, 6)) - 3);
                default: e = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
            endcase
            send_entry(e);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (det_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Register write; only called with no result pending.
    task automatic write_order(logic [CFG_BITS-1:0] v);
        i_valid     <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pred_order = (v < 2) ? 2 : (v > MAXN) ? MAXN : int'(v);
        pred_count = 0;
    endtask

    // Result checker: compares each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (det_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result det=%0d status=%0d",
                             o_determinant, o_status);
            end else begin
                t_det_result exp_r;
                exp_r = det_queue.pop_front();
                if (exp_r.det !== o_determinant || exp_r.status !== o_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp det=%0d st=%0d got det=%0d st=%0d",
                                 exp_r.det, exp_r.status, o_determinant, o_status);
                end
            end
        end
    end

    // Receiver back-pressure in random bursts.
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_enable && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 10);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    // Directed: identity, extremes, a zero top-left pivot, signs.
    task automatic test_directed();
        int k;
        write_order(3'd0);   // clamps to 2
        send_entry(12'sh7FF); send_entry(12'sh800); send_entry(12'sh800); send_entry(12'sh7FF);
        wait_drained();
        write_order(3'd7);   // clamps to 5
        for (k = 0; k < 25; k++) send_entry((k % 6 == 0) ? 12'sd1 : 12'sd0);
        wait_drained();
        write_order(3'd3);   // zero top-left pivot
        send_entry(12'sd0); for (k = 1; k < 9; k++) send_entry(EBITS'(k));
        wait_drained();
        write_order(3'd5);
        for (k = 0; k < 25; k++) send_entry((k % 2) ? 12'sh800 : 12'sh7FF);
        wait_drained();
    endtask

    // Size written mid-load restarts the load.
    task automatic test_restart();
        write_order(3'd4);
        send_entry(12'sd5); send_entry(-12'sd7); send_entry(12'sd3);
        i_valid <= 1'b0;
        repeat (5) @(posedge i_clk);
        write_order(3'd2);
        send_matrix_random(0);
        wait_drained();
    endtask

    // Random matrices over every order, small values often to hit zero pivots.
    task automatic test_random(int entries);
        int sent;
        sent = 0;
        while (sent < entries) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
                write_order(CFG_BITS'($urandom_range(0, 7)));
            end
            send_matrix_random($urandom_range(0, 9) < 6 ? 0 :
                               ($urandom_range(0, 3) != 0 ? 1 : 2));
            sent += pred_order * pred_order;
        end
        wait_drained();   // sender holds off until every result is back
    endtask

    initial begin
        mismatches  = 0;
        idle_enable = 1'b0;
        pred_order  = 2;
        pred_count  = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_element   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        idle_enable = 1'b1;
        test_restart();
        test_random(1000);
        idle_enable = 1'b0;   // closing stretch at full rate
        test_random(200);
        wait_drained();
        if (mismatches == 0 && det_queue.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/dcc_pkg.sv
rtl/dcc_divider.sv
rtl/determinant_chio_condensation_core.sv
dv/determinant_chio_condensation_core_tb.sv
